// ===== hw/rtl/tfg_pkg.sv =====
package tfg_pkg;

    localparam int unsigned TEMP_W   = 8;
    localparam int unsigned FREQ_W   = 10;
    localparam int unsigned SUPPLY_W = 10;
    localparam int unsigned WAIT_W   = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [FREQ_W-1:0] HOT_STEP      = FREQ_W'(40);
    localparam logic [FREQ_W-1:0] COOL_STEP     = FREQ_W'(20);
    localparam logic [FREQ_W-1:0] SUPPLY_STEP   = FREQ_W'(20);
    localparam logic [FREQ_W-1:0] FREQ_AT_RESET = FREQ_W'(360);

    // supply mode rechecks the supply when its tick counter reaches this value
    localparam logic [WAIT_W-1:0] SUPPLY_CHECK_TICKS = WAIT_W'(2);

    localparam logic [TEMP_W-1:0]   TEMP_LOW_RST     = TEMP_W'(60);
    localparam logic [TEMP_W-1:0]   TEMP_HIGH_RST    = TEMP_W'(65);
    localparam logic [FREQ_W-1:0]   FREQ_FLOOR_RST   = FREQ_W'(100);
    localparam logic [FREQ_W-1:0]   FREQ_CEILING_RST = FREQ_W'(360);
    localparam logic [SUPPLY_W-1:0] SUPPLY_LOW_RST   = SUPPLY_W'(450);
    localparam logic [SUPPLY_W-1:0] SUPPLY_HIGH_RST  = SUPPLY_W'(460);
    localparam logic [WAIT_W-1:0]   RISE_WAIT_RST    = WAIT_W'(1);
    localparam logic [WAIT_W-1:0]   FALL_WAIT_RST    = WAIT_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_LOW     = 3'd0,
        REG_TEMP_HIGH    = 3'd1,
        REG_FREQ_FLOOR   = 3'd2,
        REG_FREQ_CEILING = 3'd3,
        REG_SUPPLY_LOW   = 3'd4,
        REG_SUPPLY_HIGH  = 3'd5,
        REG_RISE_WAIT    = 3'd6,
        REG_FALL_WAIT    = 3'd7
    } tfg_reg_idx_t;

    typedef struct packed {
        logic [TEMP_W-1:0]   temp_low;
        logic [TEMP_W-1:0]   temp_high;
        logic [FREQ_W-1:0]   freq_floor;
        logic [FREQ_W-1:0]   freq_ceiling;
        logic [SUPPLY_W-1:0] supply_low;
        logic [SUPPLY_W-1:0] supply_high;
        logic [WAIT_W-1:0]   rise_wait;
        logic [WAIT_W-1:0]   fall_wait;
    } tfg_cfg_t;

    typedef struct packed {
        logic                power_on;
        logic [TEMP_W-1:0]   temperature;
        logic [SUPPLY_W-1:0] supply_sample;
    } tfg_item_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_target;
        logic              too_hot;
        logic              supply_mode;
    } tfg_result_t;

    // step down, saturating at the floor
    function automatic logic [FREQ_W-1:0] lower_by(input logic [FREQ_W-1:0] freq,
                                                   input logic [FREQ_W-1:0] floor_val,
                                                   input logic [FREQ_W-1:0] step);
        logic [FREQ_W:0] limit;
        limit = {1'b0, floor_val} + {1'b0, step};
        if ({1'b0, freq} < limit) begin
            return floor_val;
        end
        return freq - step;
    endfunction

endpackage

// ===== hw/rtl/thermal_frequency_governor_unit.sv =====
// Thermal and supply frequency governor.
// Input stream: one transfer per tick carries power state, temperature and a
// supply ADC code. Output stream: one transfer per tick with the frequency
// target, the too-hot flag and the regulation mode after that tick.
// Configuration: cfg_valid/cfg_index/cfg_data writes one of eight limit
// registers; cfg_ready is always high. Write only while no tick is in flight.
// Path: a tick accepted into the input register is updated through the core
// state into the result register when it advances, which waits while a held
// result blocks it. Throughput: one tick per cycle while m_tready stays high,
// set by the single state update between the input and result registers.
// Stall: while m_tready is low the result holds; one more tick is taken into
// the input register, then s_tready drops until the result leaves.
// Reset (aresetn low, synchronous): limits return to their defaults, the
// target to 360 MHz, temperature mode, flags and counters clear, and the
// temperature reference is marked not yet captured.
module thermal_frequency_governor_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [0] power_on, [8:1] temperature, [18:9] supply_sample, [23:19] ignored
    input  logic [23:0]                    s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [9:0] freq_target, [10] too_hot, [11] supply_mode, [15:12] zero
    output logic [15:0]                    m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tfg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tfg_pkg::*;

    tfg_cfg_t    cfg;
    tfg_item_t   item_reg;
    logic        in_valid_reg;
    tfg_result_t result;
    tfg_result_t out_reg;
    logic        out_valid_reg;
    logic        advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    tfg_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tfg_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.power_on      <= s_tdata[0];
            item_reg.temperature   <= s_tdata[8:1];
            item_reg.supply_sample <= s_tdata[18:9];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the result until the downstream transfer completes
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.supply_mode, out_reg.too_hot, out_reg.freq_target};

endmodule

// ===== hw/rtl/tfg_cfg_regs.sv =====
module tfg_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [tfg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfg_pkg::CFG_DATA_W-1:0] cfg_data,
    output tfg_pkg::tfg_cfg_t              cfg
);
    import tfg_pkg::*;

    tfg_cfg_t cfg_reg;
    tfg_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (tfg_reg_idx_t'(cfg_index))
                REG_TEMP_LOW:     cfg_next.temp_low     = cfg_data[TEMP_W-1:0];
                REG_TEMP_HIGH:    cfg_next.temp_high    = cfg_data[TEMP_W-1:0];
                REG_FREQ_FLOOR:   cfg_next.freq_floor   = cfg_data[FREQ_W-1:0];
                REG_FREQ_CEILING: cfg_next.freq_ceiling = cfg_data[FREQ_W-1:0];
                REG_SUPPLY_LOW:   cfg_next.supply_low   = cfg_data[SUPPLY_W-1:0];
                REG_SUPPLY_HIGH:  cfg_next.supply_high  = cfg_data[SUPPLY_W-1:0];
                REG_RISE_WAIT:    cfg_next.rise_wait    = cfg_data[WAIT_W-1:0];
                REG_FALL_WAIT:    cfg_next.fall_wait    = cfg_data[WAIT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.temp_low     <= TEMP_LOW_RST;
            cfg_reg.temp_high    <= TEMP_HIGH_RST;
            cfg_reg.freq_floor   <= FREQ_FLOOR_RST;
            cfg_reg.freq_ceiling <= FREQ_CEILING_RST;
            cfg_reg.supply_low   <= SUPPLY_LOW_RST;
            cfg_reg.supply_high  <= SUPPLY_HIGH_RST;
            cfg_reg.rise_wait    <= RISE_WAIT_RST;
            cfg_reg.fall_wait    <= FALL_WAIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/tfg_core.sv =====
module tfg_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  tfg_pkg::tfg_item_t    item,
    input  tfg_pkg::tfg_cfg_t     cfg,
    output tfg_pkg::tfg_result_t  result
);
    import tfg_pkg::*;

    logic                mode_reg, mode_next;
    logic [FREQ_W-1:0]   freq_reg, freq_next;
    logic                hot_reg, hot_next;
    logic [WAIT_W-1:0]   hold_reg, hold_next;
    logic [WAIT_W-1:0]   supply_cnt_reg, supply_cnt_next;
    logic [TEMP_W-1:0]   ref_temp_reg, ref_temp_next;

    logic [WAIT_W-1:0]   wait_sel;
    logic                act;
    logic [FREQ_W:0]     cool_sum;

    always_comb begin
        mode_next       = mode_reg;
        freq_next       = freq_reg;
        hot_next        = hot_reg;
        hold_next       = hold_reg;
        supply_cnt_next = supply_cnt_reg;
        ref_temp_next   = ref_temp_reg;

        wait_sel = (ref_temp_reg < item.temperature) ? cfg.rise_wait : cfg.fall_wait;
        act      = (hold_reg >= wait_sel);
        cool_sum = (freq_reg <= cfg.freq_ceiling)
                 ? ({1'b0, freq_reg} + {1'b0, COOL_STEP}) : {1'b0, freq_reg};

        if (!item.power_on) begin
            if (hot_reg && (item.temperature < cfg.temp_low)) begin
                hot_next = 1'b0;
            end
        end else if (!mode_reg) begin
            if (item.supply_sample < cfg.supply_low) begin
                hold_next = '0;
                mode_next = 1'b1;
            end else if (ref_temp_reg == '0) begin
                // first nonzero reading becomes the fixed reference
                ref_temp_next = item.temperature;
            end else if (!act) begin
                hold_next = hold_reg + WAIT_W'(1);
            end else begin
                hold_next = '0;
                if (item.temperature >= cfg.temp_high) begin
                    if (freq_reg > cfg.freq_floor) begin
                        freq_next = lower_by(freq_reg, cfg.freq_floor, HOT_STEP);
                    end else begin
                        freq_next = cfg.freq_floor;
                        hot_next  = 1'b1;
                    end
                end else if (item.temperature < cfg.temp_low) begin
                    hot_next = 1'b0;
                    if (cool_sum > {1'b0, cfg.freq_ceiling}) begin
                        freq_next = cfg.freq_ceiling;
                    end else begin
                        freq_next = cool_sum[FREQ_W-1:0];
                    end
                end else begin
                    hot_next = 1'b0;
                end
            end
        end else begin
            if (supply_cnt_reg == SUPPLY_CHECK_TICKS) begin
                if (item.supply_sample >= cfg.supply_low) begin
                    supply_cnt_next = '0;
                    if (item.supply_sample > cfg.supply_high) begin
                        mode_next = 1'b0;
                    end
                end else begin
                    freq_next       = lower_by(freq_reg, cfg.freq_floor, SUPPLY_STEP);
                    supply_cnt_next = WAIT_W'(1);
                end
            end else begin
                supply_cnt_next = supply_cnt_reg + WAIT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= 1'b0;
            freq_reg       <= FREQ_AT_RESET;
            hot_reg        <= 1'b0;
            hold_reg       <= '0;
            supply_cnt_reg <= '0;
            ref_temp_reg   <= '0;
        end else if (advance) begin
            mode_reg       <= mode_next;
            freq_reg       <= freq_next;
            hot_reg        <= hot_next;
            hold_reg       <= hold_next;
            supply_cnt_reg <= supply_cnt_next;
            ref_temp_reg   <= ref_temp_next;
        end
    end

    assign result.freq_target = freq_next;
    assign result.too_hot     = hot_next;
    assign result.supply_mode = mode_next;

endmodule

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tfg_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    thermal_frequency_governor_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // governor copy: limits and state
    tfg_cfg_t          gov_cfg;
    logic              gov_mode;
    logic              gov_hot;
    logic [FREQ_W-1:0] gov_freq;
    logic [WAIT_W-1:0] gov_hold;
    logic [WAIT_W-1:0] gov_supply_ticks;
    logic [TEMP_W-1:0] gov_ref;

    tfg_item_t   tick_queue[$];
    tfg_result_t expected_results[$];
    tfg_item_t   offered_tick;
    tfg_result_t seen_result;
    tfg_result_t want_result;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          stall_requests = 0;
    int          stalls_served = 0;
    int          hold_left = 0;
    int          mismatches = 0;

    // step the target down, saturating at the floor
    function automatic void drop_target(input int unsigned step);
        if (int'(gov_freq) < int'(gov_cfg.freq_floor) + int'(step)) begin
            gov_freq = gov_cfg.freq_floor;
        end else begin
            gov_freq = gov_freq - FREQ_W'(step);
        end
    endfunction

    function automatic tfg_result_t governor_tick(input tfg_item_t t);
        logic [WAIT_W-1:0] wait_lim;
        int unsigned       raised;
        tfg_result_t       r;
        if (!t.power_on) begin
            if (t.temperature < gov_cfg.temp_low) begin
                gov_hot = 1'b0;
            end
        end else if (!gov_mode) begin
            if (t.supply_sample < gov_cfg.supply_low) begin
                gov_hold = '0;
                gov_mode = 1'b1;
            end else if (gov_ref == '0) begin
                gov_ref = t.temperature;
            end else begin
                wait_lim = (gov_ref < t.temperature) ? gov_cfg.rise_wait : gov_cfg.fall_wait;
                if (gov_hold < wait_lim) begin
                    gov_hold = gov_hold + 1'b1;
                end else begin
                    gov_hold = '0;
                    if (t.temperature >= gov_cfg.temp_high) begin
                        if (gov_freq > gov_cfg.freq_floor) begin
                            drop_target(32'(HOT_STEP));
                        end else begin
                            gov_freq = gov_cfg.freq_floor;
                            gov_hot = 1'b1;
                        end
                    end else begin
                        gov_hot = 1'b0;
                        if (t.temperature < gov_cfg.temp_low) begin
                            // no step when already above the ceiling, then clamp
                            raised = 32'(gov_freq);
                            if (raised <= 32'(gov_cfg.freq_ceiling)) begin
                                raised = raised + 32'(COOL_STEP);
                            end
                            if (raised > 32'(gov_cfg.freq_ceiling)) begin
                                raised = 32'(gov_cfg.freq_ceiling);
                            end
                            gov_freq = raised[FREQ_W-1:0];
                        end
                    end
                end
            end
        end else begin
            if (gov_supply_ticks == SUPPLY_CHECK_TICKS &&
                t.supply_sample >= gov_cfg.supply_low) begin
                gov_supply_ticks = '0;
                if (t.supply_sample > gov_cfg.supply_high) begin
                    gov_mode = 1'b0;
                end
            end else if (gov_supply_ticks == SUPPLY_CHECK_TICKS) begin
                drop_target(32'(SUPPLY_STEP));
                gov_supply_ticks = WAIT_W'(1);
            end else begin
                gov_supply_ticks = gov_supply_ticks + 1'b1;
            end
        end
        r.freq_target = gov_freq;
        r.too_hot     = gov_hot;
        r.supply_mode = gov_mode;
        return r;
    endfunction

    // sender: offer queued ticks, predict on each accepted transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(governor_tick(offered_tick));
            end
            if (!s_tvalid || s_tready) begin
                if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_tick = tick_queue.pop_front();
                    s_tdata  <= {5'd0, offered_tick.supply_sample, offered_tick.temperature,
                                 offered_tick.power_on};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random back-pressure, plus long holds on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (stalls_served != stall_requests) begin
            stalls_served <= stalls_served + 1;
            hold_left     <= 60;
            m_tready      <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_result.freq_target = m_tdata[FREQ_W-1:0];
            seen_result.too_hot     = m_tdata[10];
            seen_result.supply_mode = m_tdata[11];
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result freq %0d hot %0b mode %0b", $time,
                         seen_result.freq_target, seen_result.too_hot,
                         seen_result.supply_mode);
                mismatches++;
            end else begin
                want_result = expected_results.pop_front();
                if (seen_result !== want_result) begin
                    $display("%0t: expected freq %0d hot %0b mode %0b, got freq %0d hot %0b mode %0b",
                             $time, want_result.freq_target, want_result.too_hot,
                             want_result.supply_mode, seen_result.freq_target,
                             seen_result.too_hot, seen_result.supply_mode);
                    mismatches++;
                end
            end
        end
    end

    task automatic queue_tick(input logic pwr, input int unsigned temp, input int unsigned supply);
        tfg_item_t t;
        t.power_on      = pwr;
        t.temperature   = TEMP_W'(temp);
        t.supply_sample = SUPPLY_W'(supply);
        tick_queue.push_back(t);
    endtask

    task automatic wait_for_results;
        while (tick_queue.size() != 0 || s_tvalid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input tfg_reg_idx_t idx, input int unsigned value);
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'(value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TEMP_LOW:     gov_cfg.temp_low     = v[TEMP_W-1:0];
            REG_TEMP_HIGH:    gov_cfg.temp_high    = v[TEMP_W-1:0];
            REG_FREQ_FLOOR:   gov_cfg.freq_floor   = v;
            REG_FREQ_CEILING: gov_cfg.freq_ceiling = v;
            REG_SUPPLY_LOW:   gov_cfg.supply_low   = v;
            REG_SUPPLY_HIGH:  gov_cfg.supply_high  = v;
            REG_RISE_WAIT:    gov_cfg.rise_wait    = v[WAIT_W-1:0];
            REG_FALL_WAIT:    gov_cfg.fall_wait    = v[WAIT_W-1:0];
            default: ;
        endcase
    endtask

    initial begin
        #1_000_000;
        $display("** thermal_frequency_governor_unit: FAILED **");
        $finish;
    end

    initial begin
        int unsigned reg_val[8];
        int          t;
        int          setting;
        tfg_item_t   item;

        gov_cfg.temp_low     = TEMP_LOW_RST;
        gov_cfg.temp_high    = TEMP_HIGH_RST;
        gov_cfg.freq_floor   = FREQ_FLOOR_RST;
        gov_cfg.freq_ceiling = FREQ_CEILING_RST;
        gov_cfg.supply_low   = SUPPLY_LOW_RST;
        gov_cfg.supply_high  = SUPPLY_HIGH_RST;
        gov_cfg.rise_wait    = RISE_WAIT_RST;
        gov_cfg.fall_wait    = FALL_WAIT_RST;
        gov_mode         = 1'b0;
        gov_hot          = 1'b0;
        gov_freq         = FREQ_AT_RESET;
        gov_hold         = '0;
        gov_supply_ticks = '0;
        gov_ref          = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // default limits: zero reading, capture, hot and cool steps, middle band,
        // supply mode entry, a low check and recovery, power off
        queue_tick(1'b0, 0, 0);
        queue_tick(1'b1, 0, 1023);
        queue_tick(1'b1, 70, 1023);
        repeat (4) queue_tick(1'b1, 255, 1023);
        repeat (3) queue_tick(1'b1, 0, 1023);
        repeat (2) queue_tick(1'b1, 62, 1023);
        queue_tick(1'b1, 255, 0);
        repeat (4) queue_tick(1'b1, 0, 0);
        queue_tick(1'b1, 0, 1023);
        queue_tick(1'b0, 10, 1023);
        wait_for_results();

        // overlapping temperature limits, floor above ceiling, no hold
        write_reg(REG_FREQ_FLOOR, 1000);
        write_reg(REG_FREQ_CEILING, 0);
        write_reg(REG_TEMP_LOW, 255);
        write_reg(REG_TEMP_HIGH, 0);
        write_reg(REG_RISE_WAIT, 0);
        write_reg(REG_FALL_WAIT, 0);
        queue_tick(1'b1, 200, 1023);
        queue_tick(1'b0, 254, 1023);
        queue_tick(1'b1, 255, 1023);
        wait_for_results();
        write_reg(REG_TEMP_HIGH, 255);
        queue_tick(1'b1, 100, 1023);
        wait_for_results();
        // step below zero in supply mode, supply equal to the limits
        write_reg(REG_FREQ_FLOOR, 0);
        write_reg(REG_SUPPLY_LOW, 1023);
        write_reg(REG_SUPPLY_HIGH, 1023);
        repeat (4) queue_tick(1'b1, 10, 0);
        repeat (3) queue_tick(1'b1, 1, 1023);
        wait_for_results();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 35; recv_idle_pct = 75; end
                1: begin send_idle_pct = 75; recv_idle_pct = 35; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int chunk = 0; chunk < 3; chunk++) begin
                setting = ph * 3 + chunk;
                if (setting == 4) begin
                    reg_val[REG_TEMP_LOW]     = 255;
                    reg_val[REG_TEMP_HIGH]    = 255;
                    reg_val[REG_FREQ_FLOOR]   = 1000;
                    reg_val[REG_FREQ_CEILING] = 1000;
                    reg_val[REG_SUPPLY_LOW]   = 1023;
                    reg_val[REG_SUPPLY_HIGH]  = 1023;
                    reg_val[REG_RISE_WAIT]    = 15;
                    reg_val[REG_FALL_WAIT]    = 15;
                end else if (setting == 7) begin
                    foreach (reg_val[i]) reg_val[i] = 0;
                end else begin
                    reg_val[REG_TEMP_LOW]     = $urandom_range(20, 100);
                    reg_val[REG_TEMP_HIGH]    = ($urandom_range(4) == 0) ?
                                                $urandom_range(0, reg_val[REG_TEMP_LOW]) :
                                                reg_val[REG_TEMP_LOW] + $urandom_range(0, 20);
                    reg_val[REG_FREQ_FLOOR]   = $urandom_range(0, 400);
                    reg_val[REG_FREQ_CEILING] = $urandom_range(200, 1000);
                    reg_val[REG_SUPPLY_LOW]   = $urandom_range(350, 600);
                    reg_val[REG_SUPPLY_HIGH]  = reg_val[REG_SUPPLY_LOW] + $urandom_range(0, 60);
                    reg_val[REG_RISE_WAIT]    = $urandom_range(0, 5);
                    reg_val[REG_FALL_WAIT]    = $urandom_range(0, 5);
                end
                for (int i = 0; i < 8; i++) begin
                    write_reg(tfg_reg_idx_t'(i), reg_val[i]);
                end

                // hold the result side while the sender keeps offering
                if (ph == 2 && chunk == 0) begin
                    stall_requests++;
                end

                for (int n = 0; n < 55; n++) begin
                    case ($urandom_range(9))
                        0, 1, 2: t = $urandom_range(0, 255);
                        3, 4, 5: t = int'(gov_cfg.temp_high) + int'($urandom_range(0, 8)) - 4;
                        6, 7, 8: t = int'(gov_cfg.temp_low) + int'($urandom_range(0, 8)) - 4;
                        default: t = $urandom_range(1) ? 255 : 0;
                    endcase
                    if (t < 0) t = 0;
                    if (t > 255) t = 255;
                    item.power_on    = ($urandom_range(99) < 92);
                    item.temperature = t[TEMP_W-1:0];
                    if ($urandom_range(9) < 7) begin
                        item.supply_sample = SUPPLY_W'($urandom_range(gov_cfg.supply_low, 1023));
                    end else begin
                        item.supply_sample = SUPPLY_W'($urandom_range(0, 1023));
                    end
                    tick_queue.push_back(item);
                end
                wait_for_results();
            end
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("** thermal_frequency_governor_unit: PASSED **");
        end else begin
            $display("** thermal_frequency_governor_unit: FAILED **");
        end
        $finish;
    end

endmodule
